// File: hdl/afnl_pkg.sv
// Types, codes and a helper function shared by the field lookup block.
`default_nettype none
package afnl_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] STATUS_LOADED   = 3'd0;
    localparam logic [2:0] STATUS_DROPPED  = 3'd1;
    localparam logic [2:0] STATUS_ANSWERED = 3'd2;
    localparam logic [2:0] STATUS_NONE     = 3'd3;
    localparam logic [2:0] STATUS_CLEARED  = 3'd4;

    localparam logic [39:0] MAX_DIST_SQ_RESET = 40'd1000000000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        point_radius;
        logic signed [31:0] point_height;
        logic signed [31:0] point_er;
        logic signed [31:0] point_ez;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
    } out_t;

    typedef struct packed {
        logic [30:0]        radius;
        logic signed [31:0] height;
        logic signed [31:0] er;
        logic signed [31:0] ez;
    } entry_t;

    typedef enum logic {
        DS_OP_SQRT,
        DS_OP_DIV
    } ds_op_t;

    typedef struct packed {
        logic   start;
        ds_op_t op;
    } ds_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

    // Applies the sign to a truncated magnitude and saturates to 32 bits.
    function automatic logic [31:0] sat_signed(input logic [63:0] q, input logic neg);
        logic [63:0] qs;
        qs = 64'd0;
        if (neg) begin
            qs = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
            return 32'd0 - qs[31:0];
        end
        qs = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
        return qs[31:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/afnl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module afnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/afnl_divsqrt.sv
// Shared shift-subtract unit for the integer square root and the 64 by 32 bit division.
`default_nettype none
module afnl_divsqrt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire afnl_pkg::ds_req_t   req,
    input  wire logic [63:0]         operand_a,
    input  wire logic [31:0]         operand_d,
    output afnl_pkg::ds_stat_t       stat,
    output logic [63:0]              result
);
    import afnl_pkg::*;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQRT,
        DS_DIV
    } ds_state_t;

    ds_state_t   state_reg;
    ds_op_t      op_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [63:0] trial;
    logic [32:0] shifted;

    assign trial   = res_reg + bit_reg;
    assign shifted = {rem_reg, quo_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
            op_reg    <= DS_OP_SQRT;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DS_IDLE: begin
                    if (req.start) begin
                        op_reg <= req.op;
                        if (req.op == DS_OP_SQRT) begin
                            v_reg     <= operand_a;
                            res_reg   <= 64'd0;
                            bit_reg   <= 64'h4000_0000_0000_0000;
                            cnt_reg   <= 6'd31;
                            state_reg <= DS_SQRT;
                        end else begin
                            quo_reg   <= operand_a;
                            rem_reg   <= 32'd0;
                            den_reg   <= operand_d;
                            cnt_reg   <= 6'd63;
                            state_reg <= DS_DIV;
                        end
                    end
                end
                DS_SQRT: begin
                    if (v_reg >= trial) begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= DS_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                DS_DIV: begin
                    if (shifted >= {1'b0, den_reg}) begin
                        rem_reg <= 32'(shifted - {1'b0, den_reg});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= shifted[31:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= DS_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= DS_IDLE;
            endcase
        end
    end

    assign stat.busy = (state_reg != DS_IDLE);
    assign stat.done = done_reg;
    assign result    = (op_reg == DS_OP_SQRT) ? res_reg : quo_reg;
endmodule
`default_nettype wire

// File: hdl/afnl_scan.sv
// Pipelined nearest-sample scan over the stored table.
`default_nettype none
module afnl_scan #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                                                 aclk,
    input  wire logic                                                 aresetn,
    input  wire logic                                                 start,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]                     count,
    input  wire logic [31:0]                                          r,
    input  wire logic signed [31:0]                                   z,
    input  wire logic [39:0]                                          limit,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0]    raddr,
    input  wire afnl_pkg::entry_t                                     rdata,
    output afnl_pkg::scan_stat_t                                      stat,
    output logic signed [31:0]                                        best_er,
    output logic signed [31:0]                                        best_ez
);
    import afnl_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          active_reg;
    logic          issuing_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_inc;
    logic          s1_valid_reg;
    logic          s2_valid_reg;
    logic          s3_valid_reg;
    logic [31:0]   dr_reg;
    logic [31:0]   dz_reg;
    logic signed [31:0] er2_reg, ez2_reg, er3_reg, ez3_reg;
    logic [63:0]   sqr_reg;
    logic [63:0]   sqz_reg;
    logic [71:0]   best_reg;
    logic          found_reg;
    logic          done_reg;
    logic [32:0]   diff_r;
    logic [32:0]   diff_z;
    logic [71:0]   dist_sq;

    assign idx_inc = idx_reg + 1'b1;
    assign raddr   = idx_reg[AW-1:0];
    assign diff_r  = {2'b00, rdata.radius} - {1'b0, r};
    assign diff_z  = {rdata.height[31], rdata.height} - {z[31], z};
    assign dist_sq = {7'd0, {1'b0, sqr_reg} + {1'b0, sqz_reg}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            issuing_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            idx_reg      <= '0;
        end else begin
            done_reg     <= 1'b0;
            s1_valid_reg <= issuing_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (start) begin
                active_reg  <= 1'b1;
                issuing_reg <= (count != '0);
                idx_reg     <= '0;
                best_reg    <= {limit, 32'd0};
                found_reg   <= 1'b0;
            end else if (issuing_reg) begin
                idx_reg <= idx_inc;
                if (idx_inc == count) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (s1_valid_reg) begin
                dr_reg  <= diff_r[32] ? 32'(-diff_r) : diff_r[31:0];
                dz_reg  <= diff_z[32] ? 32'(-diff_z) : diff_z[31:0];
                er2_reg <= rdata.er;
                ez2_reg <= rdata.ez;
            end
            if (s2_valid_reg) begin
                sqr_reg <= dr_reg * dr_reg;
                sqz_reg <= dz_reg * dz_reg;
                er3_reg <= er2_reg;
                ez3_reg <= ez2_reg;
            end
            if (s3_valid_reg && (dist_sq < best_reg)) begin
                best_reg  <= dist_sq;
                best_er   <= er3_reg;
                best_ez   <= ez3_reg;
                found_reg <= 1'b1;
            end
            if (active_reg && !start && !issuing_reg && !s1_valid_reg && !s2_valid_reg
                && !s3_valid_reg) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
endmodule
`default_nettype wire

// File: hdl/axisym_field_nearest_lookup_unit.sv
// Top level of the axisymmetric field table with nearest-sample lookup.
// A load or clear transaction passes to the response state and is then registered into the output
// register once it is free. For a query, the squared-distance scan reads one table entry per cycle
// from the sample RAM through a four-stage pipeline, and the shared shift-subtract unit computes
// the square root before the scan and each of the two radial divisions after it. The block
// accepts no transaction while a query is in progress, but takes the next one while a result
// waits in the output register. The table needs no clearing pass after reset.
`default_nettype none
module axisym_field_nearest_lookup_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire afnl_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output afnl_pkg::out_t      m_data,
    input  wire logic           cfg_wr_en,
    input  wire logic [39:0]    cfg_wr_data
);
    import afnl_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SCAN_WAIT,
        ST_PX_MUL,
        ST_PX_GO,
        ST_PX_WAIT,
        ST_PY_MUL,
        ST_PY_GO,
        ST_PY_WAIT,
        ST_RESP
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [39:0]        max_dist_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [31:0]        r_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        sum_reg;
    logic [2:0]         status_reg;
    logic [31:0]        fx_reg, fy_reg, fz_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;
    logic               scan_start_reg;

    logic               accept;
    logic               ram_we;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ax, ay, aer;
    logic [31:0]        mul_a, mul_b;
    ds_req_t            ds_req;
    ds_stat_t           ds_stat;
    logic [63:0]        ds_operand;
    logic [63:0]        ds_result;
    scan_stat_t         scan_stat;
    logic signed [31:0] best_er, best_ez;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign ram_we  = accept && (s_data.mode == MODE_LOAD) && (count_reg < CW'(TABLE_DEPTH));

    assign ram_wdata.radius = s_data.point_radius;
    assign ram_wdata.height = s_data.point_height;
    assign ram_wdata.er     = s_data.point_er;
    assign ram_wdata.ez     = s_data.point_ez;

    assign ax  = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign ay  = y_reg[31] ? (~y_reg + 32'd1) : y_reg;
    assign aer = best_er[31] ? (~best_er + 32'd1) : best_er;

    always_comb begin
        mul_a = ax;
        mul_b = ax;
        unique case (state_reg)
            ST_MUL_Y: begin
                mul_a = ay;
                mul_b = ay;
            end
            ST_PX_MUL: begin
                mul_a = aer;
                mul_b = ax;
            end
            ST_PY_MUL: begin
                mul_a = aer;
                mul_b = ay;
            end
            default: begin
                mul_a = ax;
                mul_b = ax;
            end
        endcase
    end

    always_comb begin
        ds_req.start = 1'b0;
        ds_req.op    = DS_OP_SQRT;
        ds_operand   = sum_reg + prod_reg;
        unique case (state_reg)
            ST_SQRT_GO: begin
                ds_req.start = 1'b1;
            end
            ST_PX_GO, ST_PY_GO: begin
                ds_req.start = 1'b1;
                ds_req.op    = DS_OP_DIV;
                ds_operand   = prod_reg;
            end
            default: ds_req.start = 1'b0;
        endcase
    end

    afnl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    afnl_divsqrt u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ds_req),
        .operand_a (ds_operand),
        .operand_d (r_reg),
        .stat      (ds_stat),
        .result    (ds_result)
    );

    afnl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start_reg),
        .count   (count_reg),
        .r       (r_reg),
        .z       (z_reg),
        .limit   (max_dist_reg),
        .raddr   (ram_raddr),
        .rdata   (ram_rdata),
        .stat    (scan_stat),
        .best_er (best_er),
        .best_ez (best_ez)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            max_dist_reg   <= MAX_DIST_SQ_RESET;
            m_valid_reg    <= 1'b0;
            scan_start_reg <= 1'b0;
        end else begin
            scan_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                max_dist_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_MUL_X || state_reg == ST_MUL_Y || state_reg == ST_PX_MUL
                || state_reg == ST_PY_MUL) begin
                prod_reg <= mul_a * mul_b;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fx_reg <= 32'd0;
                        fy_reg <= 32'd0;
                        fz_reg <= 32'd0;
                        unique case (s_data.mode)
                            MODE_LOAD: begin
                                if (count_reg < CW'(TABLE_DEPTH)) begin
                                    count_reg  <= count_reg + 1'b1;
                                    status_reg <= STATUS_LOADED;
                                end else begin
                                    status_reg <= STATUS_DROPPED;
                                end
                                state_reg <= ST_RESP;
                            end
                            MODE_CLEAR: begin
                                count_reg  <= '0;
                                status_reg <= STATUS_CLEARED;
                                state_reg  <= ST_RESP;
                            end
                            MODE_QUERY: begin
                                x_reg     <= s_data.pos_x;
                                y_reg     <= s_data.pos_y;
                                z_reg     <= s_data.pos_z;
                                state_reg <= ST_MUL_X;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL_X: state_reg <= ST_MUL_Y;
                ST_MUL_Y: begin
                    sum_reg   <= prod_reg;
                    state_reg <= ST_SQRT_GO;
                end
                ST_SQRT_GO: state_reg <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: begin
                    if (ds_stat.done) begin
                        r_reg          <= ds_result[31:0];
                        scan_start_reg <= 1'b1;
                        state_reg      <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT: begin
                    if (scan_stat.done) begin
                        if (!scan_stat.found) begin
                            status_reg <= STATUS_NONE;
                            state_reg  <= ST_RESP;
                        end else begin
                            status_reg <= STATUS_ANSWERED;
                            fz_reg     <= best_ez;
                            state_reg  <= (r_reg == 32'd0) ? ST_RESP : ST_PX_MUL;
                        end
                    end
                end
                ST_PX_MUL: state_reg <= ST_PX_GO;
                ST_PX_GO:  state_reg <= ST_PX_WAIT;
                ST_PX_WAIT: begin
                    if (ds_stat.done) begin
                        fx_reg    <= sat_signed(ds_result, best_er[31] != x_reg[31]);
                        state_reg <= ST_PY_MUL;
                    end
                end
                ST_PY_MUL: state_reg <= ST_PY_GO;
                ST_PY_GO:  state_reg <= ST_PY_WAIT;
                ST_PY_WAIT: begin
                    if (ds_stat.done) begin
                        fy_reg    <= sat_signed(ds_result, best_er[31] != y_reg[31]);
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.status  <= status_reg;
                        m_data_reg.field_x <= fx_reg;
                        m_data_reg.field_y <= fy_reg;
                        m_data_reg.field_z <= fz_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("Sample count exceeds the table depth.");

    a_scan_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.done |-> state_reg == ST_SCAN_WAIT)
        else $error("Scan finished outside a query.");

    a_ds_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_stat.done |-> (state_reg == ST_SQRT_WAIT || state_reg == ST_PX_WAIT
                          || state_reg == ST_PY_WAIT))
        else $error("Arithmetic unit finished while no result was awaited.");

    a_zero_unless_answered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_ANSWERED) |->
        (m_data.field_x == 32'd0 && m_data.field_y == 32'd0 && m_data.field_z == 32'd0))
        else $error("Non-zero field in a transaction that is not an answer.");
`endif

endmodule
`default_nettype wire
